// ----- hdl/twe_odo_pkg.sv -----
// ----------------------------------------------------------------------------
// twe_odo_pkg: shared definitions for the two-wheel encoder odometry
// Operation codes, register map, register reset values and defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package twe_odo_pkg;

  // Default width of the wrapping tick counters.
  localparam int COUNT_WIDTH_DEFAULT = 32;

  // Operation carried by one input item.
  typedef enum logic [1:0] {
    OP_RIGHT_EDGE = 2'd0,
    OP_LEFT_EDGE  = 2'd1,
    OP_SAMPLE     = 2'd2
  } op_t;

  // Register indexes (byte address is four times the index).
  localparam logic [2:0] REG_RIGHT_CM      = 3'd0;
  localparam logic [2:0] REG_LEFT_CM       = 3'd1;
  localparam logic [2:0] REG_RIGHT_RAD_POS = 3'd2;
  localparam logic [2:0] REG_RIGHT_RAD_NEG = 3'd3;
  localparam logic [2:0] REG_LEFT_RAD_POS  = 3'd4;
  localparam logic [2:0] REG_LEFT_RAD_NEG  = 3'd5;

  // Reset values, unsigned Q0.32.
  localparam logic [31:0] RIGHT_CM_RESET      = 32'd33745039;
  localparam logic [31:0] LEFT_CM_RESET       = 32'd34022776;
  localparam logic [31:0] RIGHT_RAD_POS_RESET = 32'd1930196;
  localparam logic [31:0] RIGHT_RAD_NEG_RESET = 32'd1809688;
  localparam logic [31:0] LEFT_RAD_POS_RESET  = 32'd1841927;
  localparam logic [31:0] LEFT_RAD_NEG_RESET  = 32'd1835288;

  // Fraction bits dropped when forming the outputs.
  localparam int DIST_SHIFT = 17;  // Q0.32 * ticks / 2 -> Q16.16
  localparam int HEAD_SHIFT = 9;   // Q0.32 * ticks / 2 -> Q8.24

endpackage

`default_nettype wire

// ----- hdl/two_wheel_encoder_odometry.sv -----
// ----------------------------------------------------------------------------
// two_wheel_encoder_odometry: quadrature tick counting and differential odometry
// Counts encoder edges for two wheels and turns sampled deltas into distance
// and heading change.
// ----------------------------------------------------------------------------
`default_nettype none

// The block takes one item per clock cycle while s_axis_tready is high, edge
// items and sample items alike. An edge item updates its wheel's tick counter
// at the edge that accepts it and gives no result. A sample item passes three
// registered stages before its result is offered on the result port: the
// first stage takes the wrapped deltas from the counters and saturates them
// to 32 bits, the second forms the four scale products (one 32 by 33 bit
// multiplier each), and the third adds, shifts and saturates into the output
// register. Each stage holds its item while the one after it is full and
// stalled, so s_axis_tready drops only when all three stages hold sample
// items and m_axis_tready is low. The user must write scale registers over
// the APB port only while the block is idle; the block itself does not
// enforce it. pready is always high.
module two_wheel_encoder_odometry #(
  parameter int COUNT_WIDTH = twe_odo_pkg::COUNT_WIDTH_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // Input item: [1:0] operation, [2] chan_a, [3] chan_b, [7:4] zero.
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,
  // Result item: [31:0] right_ticks, [63:32] left_ticks, [95:64] right_delta,
  // [127:96] left_delta, [159:128] distance, [191:160] heading_change.
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [191:0]      m_axis_tdata,
  // Configuration port.
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  import twe_odo_pkg::*;

  localparam int EXT = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
  localparam logic signed [EXT-1:0] DELTA_HI = EXT'(32'sh7FFF_FFFF);
  localparam logic signed [EXT-1:0] DELTA_LO = EXT'(32'sh8000_0000);
  localparam logic signed [64:0]    OUT_HI   = 65'sh0_7FFF_FFFF;
  localparam logic signed [64:0]    OUT_LO   = -65'sh0_8000_0000;

  // Saturate a wrapped counter difference to 32 bits.
  function automatic logic signed [31:0] sat_delta(input logic [COUNT_WIDTH-1:0] diff);
    logic signed [EXT-1:0] wide;
    wide = EXT'(signed'(diff));
    if (wide > DELTA_HI) begin
      return 32'sh7FFF_FFFF;
    end else if (wide < DELTA_LO) begin
      return 32'sh8000_0000;
    end
    return wide[31:0];
  endfunction

  // Count sign-extended (or wrapped) to 32 bits.
  function automatic logic [31:0] ticks32(input logic [COUNT_WIDTH-1:0] cnt);
    logic signed [EXT-1:0] wide;
    wide = EXT'(signed'(cnt));
    return wide[31:0];
  endfunction

  function automatic logic [31:0] sat_out(input logic signed [64:0] v);
    if (v > OUT_HI) begin
      return 32'h7FFF_FFFF;
    end else if (v < OUT_LO) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [31:0] right_cm;
  logic [31:0] left_cm;
  logic [31:0] right_rad_pos;
  logic [31:0] right_rad_neg;
  logic [31:0] left_rad_pos;
  logic [31:0] left_rad_neg;

  logic [2:0] reg_index;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      right_cm      <= RIGHT_CM_RESET;
      left_cm       <= LEFT_CM_RESET;
      right_rad_pos <= RIGHT_RAD_POS_RESET;
      right_rad_neg <= RIGHT_RAD_NEG_RESET;
      left_rad_pos  <= LEFT_RAD_POS_RESET;
      left_rad_neg  <= LEFT_RAD_NEG_RESET;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_RIGHT_CM:      right_cm      <= pwdata;
        REG_LEFT_CM:       left_cm       <= pwdata;
        REG_RIGHT_RAD_POS: right_rad_pos <= pwdata;
        REG_RIGHT_RAD_NEG: right_rad_neg <= pwdata;
        REG_LEFT_RAD_POS:  left_rad_pos  <= pwdata;
        REG_LEFT_RAD_NEG:  left_rad_neg  <= pwdata;
        default: ;  // Addresses past the map are ignored.
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_RIGHT_CM:      prdata = right_cm;
      REG_LEFT_CM:       prdata = left_cm;
      REG_RIGHT_RAD_POS: prdata = right_rad_pos;
      REG_RIGHT_RAD_NEG: prdata = right_rad_neg;
      REG_LEFT_RAD_POS:  prdata = left_rad_pos;
      REG_LEFT_RAD_NEG:  prdata = left_rad_neg;
      default:           prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake and pipeline advance
  // --------------------------------------------------------------------------
  logic s1_valid;
  logic s2_valid;
  logic s2_adv;
  logic s1_adv;
  logic in_fire;
  logic sample_fire;
  logic [1:0] op;
  logic same;

  assign s2_adv        = !m_axis_tvalid || m_axis_tready;
  assign s1_adv        = !s2_valid || s2_adv;
  assign s_axis_tready = !s1_valid || s1_adv;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign op            = s_axis_tdata[1:0];
  assign same          = (s_axis_tdata[2] == s_axis_tdata[3]);
  assign sample_fire   = in_fire && (op == OP_SAMPLE);

  // --------------------------------------------------------------------------
  // Tick counters
  // --------------------------------------------------------------------------
  logic [COUNT_WIDTH-1:0] right_count;
  logic [COUNT_WIDTH-1:0] left_count;
  logic [COUNT_WIDTH-1:0] right_prev;
  logic [COUNT_WIDTH-1:0] left_prev;

  always_ff @(posedge clk) begin
    if (rst) begin
      right_count <= '0;
      left_count  <= '0;
      right_prev  <= '0;
      left_prev   <= '0;
    end else if (in_fire) begin
      // The right wheel counts up when A equals B, the left wheel down.
      if (op == OP_RIGHT_EDGE) begin
        right_count <= same ? right_count + COUNT_WIDTH'(1)
                            : right_count - COUNT_WIDTH'(1);
      end else if (op == OP_LEFT_EDGE) begin
        left_count <= same ? left_count - COUNT_WIDTH'(1)
                           : left_count + COUNT_WIDTH'(1);
      end else if (op == OP_SAMPLE) begin
        right_prev <= right_count;
        left_prev  <= left_count;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: deltas and counts of a sample
  // --------------------------------------------------------------------------
  logic        [31:0] s1_right_ticks;
  logic        [31:0] s1_left_ticks;
  logic signed [31:0] s1_right_delta;
  logic signed [31:0] s1_left_delta;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= sample_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_fire) begin
      s1_right_ticks <= ticks32(right_count);
      s1_left_ticks  <= ticks32(left_count);
      s1_right_delta <= sat_delta(right_count - right_prev);
      s1_left_delta  <= sat_delta(left_count - left_prev);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: scale products
  // --------------------------------------------------------------------------
  logic signed [32:0] right_rad_sel;
  logic signed [32:0] left_rad_sel;
  logic signed [64:0] prod_right_cm;
  logic signed [64:0] prod_left_cm;
  logic signed [64:0] prod_right_rad;
  logic signed [64:0] prod_left_rad;

  // A delta that is zero or negative takes the reverse scale.
  assign right_rad_sel  = signed'({1'b0, (s1_right_delta > 32'sd0) ? right_rad_pos
                                                                  : right_rad_neg});
  assign left_rad_sel   = signed'({1'b0, (s1_left_delta > 32'sd0) ? left_rad_pos
                                                                 : left_rad_neg});
  assign prod_right_cm  = s1_right_delta * signed'({1'b0, right_cm});
  assign prod_left_cm   = s1_left_delta * signed'({1'b0, left_cm});
  assign prod_right_rad = s1_right_delta * right_rad_sel;
  assign prod_left_rad  = s1_left_delta * left_rad_sel;

  logic        [31:0] s2_right_ticks;
  logic        [31:0] s2_left_ticks;
  logic        [31:0] s2_right_delta;
  logic        [31:0] s2_left_delta;
  logic signed [63:0] s2_p_right_cm;
  logic signed [63:0] s2_p_left_cm;
  logic signed [63:0] s2_p_right_rad;
  logic signed [63:0] s2_p_left_rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      s2_right_ticks <= s1_right_ticks;
      s2_left_ticks  <= s1_left_ticks;
      s2_right_delta <= s1_right_delta;
      s2_left_delta  <= s1_left_delta;
      s2_p_right_cm  <= prod_right_cm[63:0];
      s2_p_left_cm   <= prod_left_cm[63:0];
      s2_p_right_rad <= prod_right_rad[63:0];
      s2_p_left_rad  <= prod_left_rad[63:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: sum, floor shift and saturation into the output register
  // --------------------------------------------------------------------------
  logic signed [64:0] dist_sum;
  logic signed [64:0] head_sum;
  logic signed [64:0] dist_q;
  logic signed [64:0] head_q;

  assign dist_sum = s2_p_right_cm + s2_p_left_cm;
  assign head_sum = s2_p_right_rad - s2_p_left_rad;
  // Arithmetic shifts round toward minus infinity.
  assign dist_q   = dist_sum >>> DIST_SHIFT;
  assign head_q   = head_sum >>> HEAD_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s2_adv) begin
      m_axis_tvalid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s2_valid) begin
      m_axis_tdata <= {sat_out(head_q), sat_out(dist_q), s2_left_delta,
                       s2_right_delta, s2_left_ticks, s2_right_ticks};
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A right edge moves the right counter and leaves the left counter alone.
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && op == OP_RIGHT_EDGE) |=>
      (right_count != $past(right_count)) && (left_count == $past(left_count)))
    else $error("right edge did not update only the right counter");

  // A sample records the counts it was taken from.
  assert property (@(posedge clk) disable iff (rst)
    sample_fire |=> (right_prev == $past(right_count)) && (left_prev == $past(left_count)))
    else $error("sample did not record the previous counts");

  // A stage 1 item that cannot move on is held unchanged.
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> s1_valid && $stable(s1_right_delta) && $stable(s1_left_delta))
    else $error("stalled stage 1 item was lost or changed");

  // A sample item always finds room in stage 1.
  assert property (@(posedge clk) disable iff (rst)
    sample_fire |=> s1_valid)
    else $error("accepted sample did not enter stage 1");

endmodule

`default_nettype wire
